// ===== rtl/prau_pkg.sv =====
// ----------------------------------------------------------------------------
// prau_pkg: shared definitions for the pivot rotation unit
// Widths, fixed-point constants, the CORDIC arctangent table, the gain
// constant and the control types that travel along the pipeline.
// ----------------------------------------------------------------------------
package prau_pkg;

   // Default parameter values.
   localparam int COORD_WIDTH_DEF   = 32;
   localparam int CORDIC_STAGES_DEF = 16;

   // Fixed formats.
   localparam int GUARD_BITS  = 8;
   localparam int ANGLE_WIDTH = 16;
   localparam int ANGLE_SHIFT = 18;
   localparam int ANG_W       = 35;
   localparam int GAIN_W      = 30;
   localparam int GAIN_FRAC   = 30;

   // Pipeline depth outside the CORDIC cells.
   localparam int FRONT_LAT = 3;
   localparam int GAIN_LAT  = 4;

   // Angle constants in Q30.
   localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
   localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
   localparam longint                  Q30_KINF    = 64'sd652032874;

   // Arctangent of 2^-i in Q30, truncated.
   localparam logic [ANG_W-1:0] ATAN_TABLE [32] = '{
      35'h3243F6A8, 35'h1DAC6705, 35'h0FADBAFC, 35'h07F56EA6,
      35'h03FEAB76, 35'h01FFD55B, 35'h00FFFAAA, 35'h007FFF55,
      35'h003FFFEA, 35'h001FFFFD, 35'h000FFFFF, 35'h0007FFFF,
      35'h0003FFFF, 35'h0001FFFF, 35'h0000FFFF, 35'h00007FFF,
      35'h00003FFF, 35'h00001FFF, 35'h00000FFF, 35'h000007FF,
      35'h000003FF, 35'h000001FF, 35'h000000FF, 35'h0000007F,
      35'h0000003F, 35'h0000001F, 35'h0000000F, 35'h00000008,
      35'h00000004, 35'h00000002, 35'h00000001, 35'h00000000
   };

   // Rotation axis codes.
   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   // Control that travels beside each request.
   typedef struct packed {
      logic     valid;
      axis_type kind;
   } ctrl_type;

   // Gain compensation in Q30 for a given number of stages.
   function automatic logic [GAIN_W-1:0] gain_q30(input int stages);
      longint t;
      longint extra;
      int     sh;
      sh    = 2 * stages;
      t     = Q30_KINF * 2 / 3;
      extra = 0;
      if (sh < 40) begin
         extra = (t + (64'sd1 <<< (sh - 1))) >>> sh;
      end
      return GAIN_W'(Q30_KINF + extra);
   endfunction

endpackage

// ===== rtl/point_axis_rotation_about_pivot_unit.sv =====
// ----------------------------------------------------------------------------
// point_axis_rotation_about_pivot_unit: rotate a point about an axis line
// Rotates a Q16.16 point about the x, y or z axis through a pivot by a
// Q3.12 angle in radians, with a pipelined CORDIC and saturating outputs.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising clock edge where start is high and busy is
// low. The block is fully pipelined, so busy stays low and a new request
// may be given in every cycle: throughput is one point per clock.
// Each result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid. On its way each request passes through three front stages
// (axis select, offset and angle wrap, quadrant fold), one cell per
// CORDIC stage, and four gain/round/clamp stages.
// Results leave in request order. The receiver cannot stall the block and
// there is no storage that would need it to.
// Axis code 3 passes the point through unchanged with the flag clear.
// A synchronous reset clears all valid bits in the pipeline; requests in
// flight are dropped and no result is produced for them.
// ----------------------------------------------------------------------------
module point_axis_rotation_about_pivot_unit
   import prau_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_kind,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_pivot_x,
   input  logic signed [COORD_WIDTH-1:0] req_pivot_y,
   input  logic signed [COORD_WIDTH-1:0] req_pivot_z,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_saturated
);

   localparam int W  = COORD_WIDTH;
   localparam int S  = CORDIC_STAGES;
   localparam int DW = COORD_WIDTH + GUARD_BITS + 4;
   localparam int SW = 3 * COORD_WIDTH;

   // Front stage 0: axis select.
   ctrl_type                ctrl0_ff, ctrl0_in;
   logic signed [W-1:0]     pa, qa, pb, qb, sa, sb, sc;
   logic signed [W-1:0]     pa0_ff, qa0_ff, pb0_ff, qb0_ff;
   logic [SW-1:0]           side0_ff;
   logic signed [ANG_W-1:0] ang0_ff;

   // Front stage 1: offsets and angle wrap.
   ctrl_type                ctrl1_ff;
   logic signed [W:0]       da, db;
   logic signed [DW-1:0]    a1_ff, b1_ff, a1_in, b1_in;
   logic signed [ANG_W-1:0] ang1_ff, ang1_in;
   logic [SW-1:0]           side1_ff;

   // Front stage 2: quadrant fold.
   ctrl_type                ctrl2_ff;
   logic signed [DW-1:0]    a2_ff, b2_ff, a2_in, b2_in;
   logic signed [ANG_W-1:0] ang2_ff, ang2_in;
   logic [SW-1:0]           side2_ff;

   // CORDIC chain.
   ctrl_type                ctrl_chain [S+1];
   logic signed [DW-1:0]    a_chain    [S+1];
   logic signed [DW-1:0]    b_chain    [S+1];
   logic signed [ANG_W-1:0] ang_chain  [S+1];
   logic [SW-1:0]           side_chain [S+1];

   // Gain stage alignment.
   ctrl_type                ctrl_g_ff [GAIN_LAT];
   logic [SW-1:0]           side_g_ff [GAIN_LAT];
   logic signed [W-1:0]     ra, rb;
   logic                    sat_a, sat_b;
   ctrl_type                ctrl_out;
   logic [SW-1:0]           side_out;
   logic signed [W-1:0]     so_a, so_b, so_c;

   // The pipeline takes a request every cycle.
   assign busy = 1'b0;

   // Pick the rotated pair and the side values for the axis.
   always_comb begin
      unique case (axis_type'(req_kind))
         AXIS_X: begin
            pa = req_point_z; qa = req_pivot_z;
            pb = req_point_y; qb = req_pivot_y;
            sa = req_pivot_z; sb = req_pivot_y; sc = req_point_x;
         end
         AXIS_Y: begin
            pa = req_point_x; qa = req_pivot_x;
            pb = req_point_z; qb = req_pivot_z;
            sa = req_pivot_x; sb = req_pivot_z; sc = req_point_y;
         end
         AXIS_Z: begin
            pa = req_point_x; qa = req_pivot_x;
            pb = req_point_y; qb = req_pivot_y;
            sa = req_pivot_x; sb = req_pivot_y; sc = req_point_z;
         end
         AXIS_NONE: begin
            pa = '0; qa = '0;
            pb = '0; qb = '0;
            sa = req_point_x; sb = req_point_y; sc = req_point_z;
         end
      endcase
   end

   assign ctrl0_in = '{valid: start & ~busy, kind: axis_type'(req_kind)};

   // Control registers of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
      end else begin
         ctrl0_ff <= ctrl0_in;
         ctrl1_ff <= ctrl0_ff;
         ctrl2_ff <= ctrl1_ff;
      end
   end

   // Stage 0 payload: selected operands and the angle in Q30.
   always_ff @(posedge clock) begin
      pa0_ff   <= pa;
      qa0_ff   <= qa;
      pb0_ff   <= pb;
      qb0_ff   <= qb;
      side0_ff <= {sa, sb, sc};
      ang0_ff  <= ANG_W'(req_angle) <<< ANGLE_SHIFT;
   end

   // Stage 1: offsets with guard bits, and the angle wrapped into [-pi, pi].
   assign da    = {pa0_ff[W-1], pa0_ff} - {qa0_ff[W-1], qa0_ff};
   assign db    = {pb0_ff[W-1], pb0_ff} - {qb0_ff[W-1], qb0_ff};
   assign a1_in = {{(DW-W-1-GUARD_BITS){da[W]}}, da, {GUARD_BITS{1'b0}}};
   assign b1_in = {{(DW-W-1-GUARD_BITS){db[W]}}, db, {GUARD_BITS{1'b0}}};

   always_comb begin
      if (ang0_ff > Q30_PI) begin
         ang1_in = ang0_ff - Q30_TWO_PI;
      end else if (ang0_ff < -Q30_PI) begin
         ang1_in = ang0_ff + Q30_TWO_PI;
      end else begin
         ang1_in = ang0_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff    <= a1_in;
      b1_ff    <= b1_in;
      ang1_ff  <= ang1_in;
      side1_ff <= side0_ff;
   end

   // Stage 2: fold angles beyond a quarter turn by negating the pair.
   always_comb begin
      if (ang1_ff > Q30_HALF_PI) begin
         a2_in   = -a1_ff;
         b2_in   = -b1_ff;
         ang2_in = ang1_ff - Q30_PI;
      end else if (ang1_ff < -Q30_HALF_PI) begin
         a2_in   = -a1_ff;
         b2_in   = -b1_ff;
         ang2_in = ang1_ff + Q30_PI;
      end else begin
         a2_in   = a1_ff;
         b2_in   = b1_ff;
         ang2_in = ang1_ff;
      end
   end

   always_ff @(posedge clock) begin
      a2_ff    <= a2_in;
      b2_ff    <= b2_in;
      ang2_ff  <= ang2_in;
      side2_ff <= side1_ff;
   end

   // Row of CORDIC cells.
   assign ctrl_chain[0] = ctrl2_ff;
   assign a_chain[0]    = a2_ff;
   assign b_chain[0]    = b2_ff;
   assign ang_chain[0]  = ang2_ff;
   assign side_chain[0] = side2_ff;

   for (genvar s = 0; s < S; s++) begin : g_cell
      prau_cordic_cell #(
         .DW    (DW),
         .SW    (SW),
         .STAGE (s)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl_i (ctrl_chain[s]),
         .a_i    (a_chain[s]),
         .b_i    (b_chain[s]),
         .ang_i  (ang_chain[s]),
         .side_i (side_chain[s]),
         .ctrl_o (ctrl_chain[s+1]),
         .a_o    (a_chain[s+1]),
         .b_o    (b_chain[s+1]),
         .ang_o  (ang_chain[s+1]),
         .side_o (side_chain[s+1])
      );
   end

   // Gain compensation and clamp for both rotated coordinates.
   prau_gain_unit #(
      .COORD_WIDTH   (COORD_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_gain_a (
      .clock    (clock),
      .value_i  (a_chain[S]),
      .pivot_i  (side_chain[S][SW-1:2*W]),
      .result_o (ra),
      .sat_o    (sat_a)
   );

   prau_gain_unit #(
      .COORD_WIDTH   (COORD_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_gain_b (
      .clock    (clock),
      .value_i  (b_chain[S]),
      .pivot_i  (side_chain[S][2*W-1:W]),
      .result_o (rb),
      .sat_o    (sat_b)
   );

   // Keep control and side values in step with the gain pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < GAIN_LAT; g++) begin
            ctrl_g_ff[g] <= '0;
         end
      end else begin
         ctrl_g_ff[0] <= ctrl_chain[S];
         for (int g = 1; g < GAIN_LAT; g++) begin
            ctrl_g_ff[g] <= ctrl_g_ff[g-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_g_ff[0] <= side_chain[S];
      for (int g = 1; g < GAIN_LAT; g++) begin
         side_g_ff[g] <= side_g_ff[g-1];
      end
   end

   assign ctrl_out = ctrl_g_ff[GAIN_LAT-1];
   assign side_out = side_g_ff[GAIN_LAT-1];
   assign so_a     = side_out[SW-1:2*W];
   assign so_b     = side_out[2*W-1:W];
   assign so_c     = side_out[W-1:0];

   // Put the rotated pair back on its coordinates.
   always_comb begin
      unique case (ctrl_out.kind)
         AXIS_X: begin
            rsp_out_x = so_c; rsp_out_y = rb; rsp_out_z = ra;
         end
         AXIS_Y: begin
            rsp_out_x = ra; rsp_out_y = so_c; rsp_out_z = rb;
         end
         AXIS_Z: begin
            rsp_out_x = ra; rsp_out_y = rb; rsp_out_z = so_c;
         end
         AXIS_NONE: begin
            rsp_out_x = so_a; rsp_out_y = so_b; rsp_out_z = so_c;
         end
      endcase
   end

   assign rsp_valid     = ctrl_out.valid;
   assign rsp_saturated = ctrl_out.valid && (ctrl_out.kind != AXIS_NONE) && (sat_a || sat_b);

endmodule

// ===== rtl/prau_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// prau_cordic_cell: one CORDIC rotation stage
// Applies the micro-rotation of its stage index to the pair, updates the
// residual angle and hands everything to the next cell each cycle.
// ----------------------------------------------------------------------------
module prau_cordic_cell
   import prau_pkg::*;
#(
   parameter int DW    = 44,
   parameter int SW    = 96,
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl_i,
   input  logic signed [DW-1:0] a_i,
   input  logic signed [DW-1:0] b_i,
   input  logic signed [ANG_W-1:0] ang_i,
   input  logic [SW-1:0]        side_i,
   output ctrl_type             ctrl_o,
   output logic signed [DW-1:0] a_o,
   output logic signed [DW-1:0] b_o,
   output logic signed [ANG_W-1:0] ang_o,
   output logic [SW-1:0]        side_o
);

   localparam logic signed [ANG_W-1:0] ATAN_STEP = ATAN_TABLE[STAGE];

   ctrl_type                ctrl_ff;
   logic signed [DW-1:0]    a_ff, a_in;
   logic signed [DW-1:0]    b_ff, b_in;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic [SW-1:0]           side_ff;
   logic signed [DW-1:0]    a_sh, b_sh;

   // Micro-rotation: direction follows the sign of the residual angle.
   assign a_sh = a_i >>> STAGE;
   assign b_sh = b_i >>> STAGE;

   always_comb begin
      if (!ang_i[ANG_W-1]) begin
         a_in   = a_i - b_sh;
         b_in   = b_i + a_sh;
         ang_in = ang_i - ATAN_STEP;
      end else begin
         a_in   = a_i + b_sh;
         b_in   = b_i - a_sh;
         ang_in = ang_i + ATAN_STEP;
      end
   end

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_i;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      ang_ff  <= ang_in;
      side_ff <= side_i;
   end

   assign ctrl_o = ctrl_ff;
   assign a_o    = a_ff;
   assign b_o    = b_ff;
   assign ang_o  = ang_ff;
   assign side_o = side_ff;

endmodule

// ===== rtl/prau_gain_unit.sv =====
// ----------------------------------------------------------------------------
// prau_gain_unit: gain compensation, rounding, pivot add and clamp
// Four-stage pipeline for one rotated coordinate: magnitude, split Q30
// products, signed sum, then guard-bit rounding, pivot add and saturation.
// ----------------------------------------------------------------------------
module prau_gain_unit
   import prau_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic signed [COORD_WIDTH+GUARD_BITS+3:0] value_i,
   input  logic signed [COORD_WIDTH-1:0] pivot_i,
   output logic signed [COORD_WIDTH-1:0] result_o,
   output logic                          sat_o
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = COORD_WIDTH + GUARD_BITS + 4;
   localparam int MW = (DW > GAIN_FRAC + 1) ? DW : GAIN_FRAC + 1;
   localparam int RW = MW + 2;
   localparam int PW = 2 * GAIN_FRAC;
   localparam logic [GAIN_W-1:0]       GAIN     = gain_q30(CORDIC_STAGES);
   localparam logic [PW-1:0]           HALF_Q30 = PW'(1) << (GAIN_FRAC - 1);
   localparam logic signed [RW-1:0]    HALF_LSB = RW'(2 ** (GUARD_BITS - 1));

   logic [DW-1:0]          abs_v;
   logic [MW-1:0]          mag_ff;
   logic                   sign1_ff, sign2_ff;
   logic signed [W-1:0]    pv1_ff, pv2_ff, pv3_ff;
   logic [MW-1:0]          prod_hi_ff, prod_hi_in;
   logic [PW-1:0]          prod_lo_ff, prod_lo_in;
   logic [MW-1:0]          rsum;
   logic signed [MW:0]     s_ff, s_in;
   logic signed [RW-1:0]   rnd, shifted, total;
   logic signed [RW-1:0]   lim_hi, lim_lo;
   logic signed [W-1:0]    result_ff, result_in;
   logic                   sat_ff, sat_in;

   // Stage 1: magnitude and sign.
   assign abs_v = value_i[DW-1] ? (~value_i + 1'b1) : value_i;

   always_ff @(posedge clock) begin
      mag_ff   <= MW'(abs_v);
      sign1_ff <= value_i[DW-1];
      pv1_ff   <= pivot_i;
   end

   // Stage 2: split products of the magnitude with the Q30 gain.
   assign prod_hi_in = MW'(mag_ff[MW-1:GAIN_FRAC]) * MW'(GAIN);
   assign prod_lo_in = PW'(mag_ff[GAIN_FRAC-1:0]) * PW'(GAIN);

   always_ff @(posedge clock) begin
      prod_hi_ff <= prod_hi_in;
      prod_lo_ff <= prod_lo_in;
      sign2_ff   <= sign1_ff;
      pv2_ff     <= pv1_ff;
   end

   // Stage 3: rounded magnitude, sign restored.
   assign rsum = prod_hi_ff + MW'((prod_lo_ff + HALF_Q30) >> GAIN_FRAC);
   assign s_in = sign2_ff ? -$signed({1'b0, rsum}) : $signed({1'b0, rsum});

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      pv3_ff <= pv2_ff;
   end

   // Stage 4: drop guard bits rounding half up, add the pivot, clamp.
   assign lim_hi  = RW'($signed({1'b0, {(W-1){1'b1}}}));
   assign lim_lo  = -lim_hi - RW'(1);
   assign rnd     = RW'(s_ff) + HALF_LSB;
   assign shifted = rnd >>> GUARD_BITS;
   assign total   = shifted + RW'(pv3_ff);

   always_comb begin
      if (total > lim_hi) begin
         result_in = lim_hi[W-1:0];
         sat_in    = 1'b1;
      end else if (total < lim_lo) begin
         result_in = lim_lo[W-1:0];
         sat_in    = 1'b1;
      end else begin
         result_in = total[W-1:0];
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      sat_ff    <= sat_in;
   end

   assign result_o = result_ff;
   assign sat_o    = sat_ff;

endmodule

// ===== rtl/prau_checker.sv =====
// ----------------------------------------------------------------------------
// prau_checker: port-level checks for the pivot rotation unit
// Checks fixed latency, the flag qualification and coordinate pass-through
// as seen on the top-level ports, and binds itself to the top level.
// ----------------------------------------------------------------------------
module prau_checker
   import prau_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [1:0]                    req_kind,
   input logic signed [COORD_WIDTH-1:0] req_point_x,
   input logic signed [COORD_WIDTH-1:0] req_point_y,
   input logic signed [COORD_WIDTH-1:0] req_point_z,
   input logic                          rsp_valid,
   input logic signed [COORD_WIDTH-1:0] rsp_out_x,
   input logic signed [COORD_WIDTH-1:0] rsp_out_y,
   input logic signed [COORD_WIDTH-1:0] rsp_out_z,
   input logic                          rsp_saturated
);

   localparam int LAT = FRONT_LAT + CORDIC_STAGES + GAIN_LAT;

   // Every accepted request gives a result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after fixed latency");

   // No result appears without a request the fixed latency earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without matching request");

   // The saturation flag is only raised with a result.
   a_flag_qualified: assert property (@(posedge clock)
      !rsp_valid |-> !rsp_saturated)
      else $error("saturation flag without result");

   // Axis code 3 returns the point itself, unflagged.
   a_no_axis_pass: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == AXIS_NONE) |-> ##LAT
      (rsp_out_x == $past(req_point_x, LAT) && rsp_out_y == $past(req_point_y, LAT) &&
       rsp_out_z == $past(req_point_z, LAT) && !rsp_saturated))
      else $error("axis code 3 did not pass the point through");

   // Rotation about z leaves z untouched.
   a_z_axis_keep: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == AXIS_Z) |-> ##LAT
      (rsp_out_z == $past(req_point_z, LAT)))
      else $error("axis coordinate changed by rotation");

endmodule

bind point_axis_rotation_about_pivot_unit prau_checker #(
   .COORD_WIDTH   (COORD_WIDTH),
   .CORDIC_STAGES (CORDIC_STAGES)
) u_prau_checker (.*);
